[sv/bsf_pkg.sv]
// package for the blocklist substring filter
// holds defaults, opcodes, result codes, fsm states and control structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsf_pkg;

  // default table geometry
  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned PATTERN_LEN_DEF = 128;

  // fixed field widths of the request and result channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 5;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REQUEST = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // result codes
  typedef enum logic [CODE_W-1:0] {
    RES_ADDED     = 3'd0,
    RES_FULL      = 3'd1,
    RES_REMOVED   = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_ALLOWED   = 3'd4,
    RES_BLOCKED   = 3'd5
  } res_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_FIN,
    ST_RM_SCAN,
    ST_RM_FIND,
    ST_RM_SHIFT,
    ST_RM_FIN,
    ST_SCAN,
    ST_REQ_FIN
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic rm_step;
    logic rm_end;
    logic find;
    logic shift_step;
    logic scan_step;
    logic add_fin;
    logic rm_fin;
    logic req_fin;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rm_scan_req;
    logic last;
    logic rm_done;
    logic shift_done;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[sv/bsf_if.sv]
// valid/ready channel interfaces of the blocklist substring filter
// depends on bsf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bsf_in_if;
  logic                         valid;
  logic                         ready;
  logic [bsf_pkg::OP_W-1:0]     operation;
  logic [bsf_pkg::BYTE_W-1:0]   data_byte;
  logic                         last;

  modport source (output valid, output operation, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input operation, input data_byte, input last,
                  output ready);
endinterface

interface bsf_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsf_pkg::CODE_W-1:0]   result_code;
  logic [bsf_pkg::SLOT_W-1:0]   match_slot;
  logic [bsf_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output result_code, output match_slot,
                  output entry_count, input ready);
  modport sink   (input valid, input result_code, input match_slot,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[sv/bsf_ctrl.sv]
// controller state machine of the blocklist substring filter
// sequences table edits and request scans; depends on bsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsf_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [bsf_pkg::OP_W-1:0]   operation_i,
  input  wire logic                       last_i,
  output logic                            in_ready_o,
  input  wire bsf_pkg::status_t           status_i,
  output bsf_pkg::cmd_t                   cmd_o
);

  bsf_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == bsf_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            bsf_pkg::OP_ADD: begin
              if (last_i) state_d = bsf_pkg::ST_ADD_FIN;
            end
            bsf_pkg::OP_REMOVE: begin
              if (status_i.rm_scan_req) state_d = bsf_pkg::ST_RM_SCAN;
              else if (last_i)          state_d = bsf_pkg::ST_RM_FIND;
            end
            bsf_pkg::OP_REQUEST: state_d = bsf_pkg::ST_SCAN;
            default:             state_d = bsf_pkg::ST_IDLE;
          endcase
        end
      end
      bsf_pkg::ST_ADD_FIN: begin
        if (status_i.out_free) state_d = bsf_pkg::ST_IDLE;
      end
      bsf_pkg::ST_RM_SCAN: begin
        if (status_i.rm_done) begin
          state_d = status_i.last ? bsf_pkg::ST_RM_FIND : bsf_pkg::ST_IDLE;
        end
      end
      bsf_pkg::ST_RM_FIND:  state_d = bsf_pkg::ST_RM_SHIFT;
      bsf_pkg::ST_RM_SHIFT: begin
        if (status_i.shift_done) state_d = bsf_pkg::ST_RM_FIN;
      end
      bsf_pkg::ST_RM_FIN: begin
        if (status_i.out_free) state_d = bsf_pkg::ST_IDLE;
      end
      bsf_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = status_i.last ? bsf_pkg::ST_REQ_FIN : bsf_pkg::ST_IDLE;
        end
      end
      bsf_pkg::ST_REQ_FIN: begin
        if (status_i.out_free) state_d = bsf_pkg::ST_IDLE;
      end
      default: state_d = bsf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bsf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bsf_pkg::ST_ADD_FIN:  cmd_o.add_fin = status_i.out_free;
      bsf_pkg::ST_RM_SCAN: begin
        cmd_o.rm_step = 1'b1;
        cmd_o.rm_end  = status_i.rm_done;
      end
      bsf_pkg::ST_RM_FIND:  cmd_o.find       = 1'b1;
      bsf_pkg::ST_RM_SHIFT: cmd_o.shift_step = 1'b1;
      bsf_pkg::ST_RM_FIN:   cmd_o.rm_fin     = status_i.out_free;
      bsf_pkg::ST_SCAN:     cmd_o.scan_step  = 1'b1;
      bsf_pkg::ST_REQ_FIN:  cmd_o.req_fin    = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/bsf_dp.sv]
// datapath of the blocklist substring filter
// pattern and match-vector memories, per-slot flags, result register; uses bsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsf_dp #(
  parameter int unsigned SLOTS       = bsf_pkg::SLOTS_DEF,
  parameter int unsigned PATTERN_LEN = bsf_pkg::PATTERN_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bsf_pkg::cmd_t                 cmd_i,
  output bsf_pkg::status_t                   status_o,
  input  wire logic [bsf_pkg::OP_W-1:0]      operation_i,
  input  wire logic [bsf_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                          last_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [bsf_pkg::CODE_W-1:0]         result_code_o,
  output logic [bsf_pkg::SLOT_W-1:0]         match_slot_o,
  output logic [bsf_pkg::COUNT_W-1:0]        entry_count_o
);

  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KW    = $clog2(PATTERN_LEN);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned AW    = SW + KW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [KW-1:0] POS_MAX   = KW'(PATTERN_LEN - 1);
  localparam logic [CW-1:0] TOTAL_MAX = CW'(SLOTS);

  // memories: pattern bytes and shift-and match bits, address {slot, position}
  logic [7:0] store_mem [DEPTH];
  logic       pv_mem    [DEPTH];
  logic [7:0] st_rd_q;
  logic       pv_rd_q;
  logic [AW-1:0] st_ra, pv_ra, st_wa, pv_wa;
  logic [7:0]    st_wd;
  logic          st_we, pv_we, pv_wd;

  // table and string state
  logic [KW-1:0] len_q [SLOTS];
  logic [CW-1:0] total_q;
  logic [KW-1:0] pos_q;
  logic          ended_q;
  logic [SLOTS-1:0] eq_q, hit_q, rv_q;
  logic [7:0]    byte_q;
  logic          last_q;

  // walk counters and read pipeline
  logic [CW-1:0] cnt_q;
  logic [KW-1:0] k_q;
  logic          fresh_q;
  logic          p_v_q, p_scan_q, p_top_q;
  logic [SW-1:0] p_s_q;
  logic [KW-1:0] p_k_q;

  // removal search and row shift
  logic          found_q;
  logic [SW-1:0] fs_q;
  logic          sh_act_q, sh_wv_q;
  logic [SW-1:0] sh_row_q;
  logic [KW-1:0] sh_k_q;
  logic [AW-1:0] sh_wa_q;

  // result register
  logic                        out_valid_q;
  logic [bsf_pkg::CODE_W-1:0]  code_q;
  logic [bsf_pkg::SLOT_W-1:0]  slot_q;
  logic [bsf_pkg::COUNT_W-1:0] count_q;

  logic [SW-1:0] cnt_slot, sh_row_nx, last_slot, f_slot, r_slot;
  logic [KW-1:0] cur_len, kk;
  logic [CW-1:0] tot_m1;
  logic          rm_go, scan_go, scan_skip, scan_bit, add_store, f_hit, r_hit, out_free;

  assign cnt_slot  = cnt_q[SW-1:0];
  assign cur_len   = len_q[cnt_slot];
  assign kk        = fresh_q ? (cur_len - KW'(1)) : k_q;
  assign sh_row_nx = sh_row_q + SW'(1);
  assign tot_m1    = total_q - CW'(1);
  assign last_slot = SW'(tot_m1);
  assign out_free  = !out_valid_q || out_ready_i;

  assign rm_go     = cmd_i.rm_step && (cnt_q != total_q);
  assign scan_go   = cmd_i.scan_step && (cnt_q != total_q) && (cur_len != '0);
  assign scan_skip = cmd_i.scan_step && (cnt_q != total_q) && (cur_len == '0);
  assign scan_bit  = ((p_k_q == '0) || (rv_q[p_s_q] && pv_rd_q)) && (st_rd_q == byte_q);
  assign add_store = (operation_i == bsf_pkg::OP_ADD) && !ended_q && (data_byte_i != '0)
                     && (pos_q < POS_MAX) && (total_q < TOTAL_MAX);

  // memory addresses and write controls
  always_comb begin
    if (cmd_i.shift_step) begin
      st_ra = {sh_row_nx, sh_k_q};
      pv_ra = {sh_row_nx, sh_k_q};
    end else if (cmd_i.rm_step) begin
      st_ra = {cnt_slot, pos_q};
      pv_ra = {cnt_slot, pos_q};
    end else begin
      st_ra = {cnt_slot, kk};
      pv_ra = {cnt_slot, kk - KW'(1)};
    end
    st_we = sh_wv_q || (cmd_i.accept && add_store);
    st_wa = sh_wv_q ? sh_wa_q : {total_q[SW-1:0], pos_q};
    st_wd = sh_wv_q ? st_rd_q : data_byte_i;
    pv_we = sh_wv_q || (p_v_q && p_scan_q);
    pv_wa = sh_wv_q ? sh_wa_q : {p_s_q, p_k_q};
    pv_wd = sh_wv_q ? pv_rd_q : scan_bit;
  end

  // pattern memory
  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_wa] <= st_wd;
    st_rd_q <= store_mem[st_ra];
  end

  // match-vector memory
  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd_q <= pv_mem[pv_ra];
  end

  // first entry equal to the removal string
  always_comb begin
    f_hit  = 1'b0;
    f_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((CW'(i) < total_q) && eq_q[i] && (len_q[i] == pos_q)) begin
        f_hit  = 1'b1;
        f_slot = SW'(i);
      end
    end
  end

  // lowest hit slot at request end, empty entries always hit
  always_comb begin
    r_hit  = 1'b0;
    r_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((CW'(i) < total_q) && (hit_q[i] || (len_q[i] == '0))) begin
        r_hit  = 1'b1;
        r_slot = SW'(i);
      end
    end
  end

  // control and table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) len_q[i] <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      ended_q     <= 1'b0;
      eq_q        <= '1;
      hit_q       <= '0;
      rv_q        <= '0;
      byte_q      <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      fresh_q     <= 1'b1;
      p_v_q       <= 1'b0;
      p_scan_q    <= 1'b0;
      p_top_q     <= 1'b0;
      p_s_q       <= '0;
      p_k_q       <= '0;
      found_q     <= 1'b0;
      fs_q        <= '0;
      sh_act_q    <= 1'b0;
      sh_wv_q     <= 1'b0;
      sh_row_q    <= '0;
      sh_k_q      <= '0;
      sh_wa_q     <= '0;
      out_valid_q <= 1'b0;
      code_q      <= '0;
      slot_q      <= '0;
      count_q     <= '0;
    end else begin
      p_v_q   <= 1'b0;
      sh_wv_q <= 1'b0;
      if (out_ready_i) out_valid_q <= 1'b0;

      // take a request
      if (cmd_i.accept) begin
        byte_q  <= data_byte_i;
        last_q  <= last_i;
        cnt_q   <= '0;
        fresh_q <= 1'b1;
        if ((operation_i == bsf_pkg::OP_ADD) && !ended_q) begin
          if (data_byte_i == '0)   ended_q <= 1'b1;
          else if (pos_q < POS_MAX) pos_q  <= pos_q + KW'(1);
        end
        if ((operation_i == bsf_pkg::OP_REMOVE) && !ended_q && (data_byte_i == '0)) begin
          ended_q <= 1'b1;
        end
      end

      // removal string compare, one slot a cycle
      if (rm_go) begin
        p_v_q    <= 1'b1;
        p_scan_q <= 1'b0;
        p_s_q    <= cnt_slot;
        cnt_q    <= cnt_q + CW'(1);
      end
      if (p_v_q && !p_scan_q) begin
        if ((pos_q >= len_q[p_s_q]) || (st_rd_q != byte_q)) eq_q[p_s_q] <= 1'b0;
      end
      if (cmd_i.rm_end && (pos_q < POS_MAX)) pos_q <= pos_q + KW'(1);

      // locate the entry to remove
      if (cmd_i.find) begin
        found_q  <= f_hit;
        fs_q     <= f_slot;
        sh_row_q <= f_slot;
        sh_k_q   <= '0;
        sh_act_q <= f_hit && (((CW+1)'(f_slot) + (CW+1)'(1)) < (CW+1)'(total_q));
      end

      // copy rows down one slot, one position a cycle
      if (cmd_i.shift_step && sh_act_q) begin
        sh_wv_q <= 1'b1;
        sh_wa_q <= {sh_row_q, sh_k_q};
        if (sh_k_q == POS_MAX) begin
          sh_k_q <= '0;
          if (((CW+1)'(sh_row_q) + (CW+1)'(2)) >= (CW+1)'(total_q)) sh_act_q <= 1'b0;
          else sh_row_q <= sh_row_nx;
        end else begin
          sh_k_q <= sh_k_q + KW'(1);
        end
      end

      // shift-and scan, one pattern position a cycle, top position first
      if (scan_skip) begin
        cnt_q   <= cnt_q + CW'(1);
        fresh_q <= 1'b1;
      end
      if (scan_go) begin
        p_v_q    <= 1'b1;
        p_scan_q <= 1'b1;
        p_s_q    <= cnt_slot;
        p_k_q    <= kk;
        p_top_q  <= (kk == (cur_len - KW'(1)));
        if (kk == '0) begin
          cnt_q   <= cnt_q + CW'(1);
          fresh_q <= 1'b1;
        end else begin
          k_q     <= kk - KW'(1);
          fresh_q <= 1'b0;
        end
      end
      if (p_v_q && p_scan_q) begin
        if (p_top_q && scan_bit) hit_q[p_s_q] <= 1'b1;
        if (p_k_q == '0)         rv_q[p_s_q]  <= 1'b1;
      end

      // finish an entry
      if (cmd_i.add_fin) begin
        out_valid_q <= 1'b1;
        slot_q      <= '0;
        if (total_q < TOTAL_MAX) begin
          len_q[total_q[SW-1:0]] <= pos_q;
          hit_q[total_q[SW-1:0]] <= 1'b0;
          rv_q[total_q[SW-1:0]]  <= 1'b0;
          total_q <= total_q + CW'(1);
          code_q  <= bsf_pkg::RES_ADDED;
          count_q <= bsf_pkg::COUNT_W'(total_q + CW'(1));
        end else begin
          code_q  <= bsf_pkg::RES_FULL;
          count_q <= bsf_pkg::COUNT_W'(total_q);
        end
        pos_q   <= '0;
        ended_q <= 1'b0;
        eq_q    <= '1;
      end

      // finish a removal
      if (cmd_i.rm_fin) begin
        out_valid_q <= 1'b1;
        if (found_q) begin
          for (int i = 0; i < SLOTS; i++) begin
            int j;
            j = (i + 1 < SLOTS) ? i + 1 : i;
            if ((i >= int'(fs_q)) && (i + 1 < SLOTS)) begin
              len_q[i] <= len_q[j];
              hit_q[i] <= hit_q[j];
              rv_q[i]  <= rv_q[j];
            end
          end
          hit_q[last_slot] <= 1'b0;
          rv_q[last_slot]  <= 1'b0;
          total_q <= tot_m1;
          code_q  <= bsf_pkg::RES_REMOVED;
          slot_q  <= bsf_pkg::SLOT_W'(fs_q);
          count_q <= bsf_pkg::COUNT_W'(tot_m1);
        end else begin
          code_q  <= bsf_pkg::RES_NOT_FOUND;
          slot_q  <= '0;
          count_q <= bsf_pkg::COUNT_W'(total_q);
        end
        pos_q   <= '0;
        ended_q <= 1'b0;
        eq_q    <= '1;
      end

      // finish a request
      if (cmd_i.req_fin) begin
        out_valid_q <= 1'b1;
        code_q  <= r_hit ? bsf_pkg::RES_BLOCKED : bsf_pkg::RES_ALLOWED;
        slot_q  <= r_hit ? bsf_pkg::SLOT_W'(r_slot) : '0;
        count_q <= bsf_pkg::COUNT_W'(total_q);
        hit_q   <= '0;
        rv_q    <= '0;
      end
    end
  end

  // status to the controller
  always_comb begin
    status_o.rm_scan_req = (operation_i == bsf_pkg::OP_REMOVE) && !ended_q
                           && (data_byte_i != '0);
    status_o.last        = last_q;
    status_o.rm_done     = (cnt_q == total_q) && !p_v_q;
    status_o.shift_done  = !sh_act_q && !sh_wv_q;
    status_o.scan_done   = (cnt_q == total_q) && !p_v_q;
    status_o.out_free    = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = code_q;
  assign match_slot_o  = slot_q;
  assign entry_count_o = count_q;

endmodule

`default_nettype wire

[sv/blocklist_substring_filter.sv]
// top level of the blocklist substring filter
// joins bsf_ctrl and bsf_dp; depends on bsf_pkg and bsf_if
//
//  port   | dir | carries
//  in_i   | in  | operation, data_byte, last (entry, removal or request byte)
//  out_o  | out | result_code, match_slot, entry_count (one per last byte)
//
// an entry's last byte also posts the result
// a non-zero removal byte is compared with every entry (one pattern-memory read per slot);
// its last byte then locates the first matching entry and posts the result,
// moving the rows of any entries above the removed slot down one slot
// a request byte walks the positions of every non-empty entry, top position first,
// through the single pattern-memory read port; its last byte also posts the result
// reset clears all control state at once, no clearing pass; memories need none
// a result waits in its output register; a last byte stalls while it is still held
`timescale 1ns / 1ps
`default_nettype none

module blocklist_substring_filter #(
  parameter int unsigned SLOTS       = bsf_pkg::SLOTS_DEF,
  parameter int unsigned PATTERN_LEN = bsf_pkg::PATTERN_LEN_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bsf_in_if.sink     in_i,
  bsf_out_if.source  out_o
);

  bsf_pkg::cmd_t    cmd;
  bsf_pkg::status_t status;
  logic             in_ready;

  assign in_i.ready = in_ready;

  bsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .last_i      (in_i.last),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bsf_dp #(
    .SLOTS       (SLOTS),
    .PATTERN_LEN (PATTERN_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (in_i.operation),
    .data_byte_i   (in_i.data_byte),
    .last_i        (in_i.last),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .result_code_o (out_o.result_code),
    .match_slot_o  (out_o.match_slot),
    .entry_count_o (out_o.entry_count)
  );

endmodule

`default_nettype wire

[sv/bsf_checker.sv]
// port-level checks of the blocklist substring filter, bound to the top level
// depends on bsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsf_checker #(
  parameter int unsigned SLOTS = bsf_pkg::SLOTS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [bsf_pkg::CODE_W-1:0]    result_code_i,
  input wire logic [bsf_pkg::SLOT_W-1:0]    match_slot_i,
  input wire logic [bsf_pkg::COUNT_W-1:0]   entry_count_i
);

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before taken");

  // only defined result codes
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> result_code_i <= bsf_pkg::RES_BLOCKED)
    else $error("undefined result code");

  // slot only named on removal or block
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_code_i != bsf_pkg::RES_REMOVED)
    && (result_code_i != bsf_pkg::RES_BLOCKED) |-> match_slot_i == '0)
    else $error("slot set on a result that names none");

  // full only reported with a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_code_i == bsf_pkg::RES_FULL)
    |-> entry_count_i == bsf_pkg::COUNT_W'(SLOTS))
    else $error("full reported with free slots");

endmodule

bind blocklist_substring_filter bsf_checker #(.SLOTS(SLOTS)) u_bsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_code_i (out_o.result_code),
  .match_slot_i  (out_o.match_slot),
  .entry_count_i (out_o.entry_count)
);

`default_nettype wire
